>>> src/mexp_pkg.sv
// Package for the modular exponentiation unit: widths, register codes, microcode table.
package mexp_pkg;

  localparam int OPW = 31;
  localparam int BIT_IDX_W = $clog2(OPW);
  localparam int CFG_IDX_W = 2;

  typedef logic [OPW-1:0]       operand_t;
  typedef logic [BIT_IDX_W-1:0] bit_idx_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MODULUS  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_EXPONENT = cfg_idx_t'(1);

  localparam operand_t MODULUS_RST  = operand_t'(670726081);
  localparam operand_t EXPONENT_RST = operand_t'(33519389);

  // Datapath action of one microcode step.
  typedef enum logic [2:0] {
    ACT_ACCEPT,
    ACT_NONE,
    ACT_REDUCE,
    ACT_INIT,
    ACT_SQR,
    ACT_MUL,
    ACT_NEXT,
    ACT_EMIT
  } act_t;

  // Jump condition of one microcode step.
  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_IN,
    C_M_SMALL,
    C_EBIT_CLR,
    C_BIT_NZ,
    C_OUT_BUSY
  } cond_t;

  typedef logic [2:0] pc_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   tgt;
  } ctrl_word_t;

  localparam pc_t PC_IDLE   = pc_t'(0);
  localparam pc_t PC_CHECK  = pc_t'(1);
  localparam pc_t PC_REDUCE = pc_t'(2);
  localparam pc_t PC_INIT   = pc_t'(3);
  localparam pc_t PC_SQR    = pc_t'(4);
  localparam pc_t PC_MUL    = pc_t'(5);
  localparam pc_t PC_NEXT   = pc_t'(6);
  localparam pc_t PC_EMIT   = pc_t'(7);

  // The program. A step whose condition holds jumps to its target, otherwise
  // the step counter advances by one; the emit step wraps around to idle.
  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t w;
    unique case (pc)
      PC_IDLE:   w = '{act: ACT_ACCEPT, cond: C_NO_IN,    tgt: PC_IDLE};
      PC_CHECK:  w = '{act: ACT_NONE,   cond: C_M_SMALL,  tgt: PC_EMIT};
      PC_REDUCE: w = '{act: ACT_REDUCE, cond: C_NEVER,    tgt: PC_IDLE};
      PC_INIT:   w = '{act: ACT_INIT,   cond: C_NEVER,    tgt: PC_IDLE};
      PC_SQR:    w = '{act: ACT_SQR,    cond: C_EBIT_CLR, tgt: PC_NEXT};
      PC_MUL:    w = '{act: ACT_MUL,    cond: C_NEVER,    tgt: PC_IDLE};
      PC_NEXT:   w = '{act: ACT_NEXT,   cond: C_BIT_NZ,   tgt: PC_SQR};
      PC_EMIT:   w = '{act: ACT_EMIT,   cond: C_OUT_BUSY, tgt: PC_EMIT};
    endcase
    return w;
  endfunction

endpackage

>>> src/mexp_if.sv
// Handshake channel interfaces of the modular exponentiation unit.
interface mexp_in_if import mexp_pkg::*; ();
  logic     valid;
  logic     ready;
  operand_t base;
  modport source (output valid, output base, input ready);
  modport sink   (input valid, input base, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic     valid;
  logic     ready;
  operand_t power_mod;
  modport source (output valid, output power_mod, input ready);
  modport sink   (input valid, input power_mod, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  operand_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: microcoded square-and-multiply.
//
//   Channel   Direction  Payload            Meaning
//   in_ch     sink       base[30:0]         value to raise to the exponent
//   out_ch    source     power_mod[30:0]    base^exponent mod modulus
//   cfg_ch    sink       index[1:0], data   0: modulus, 1: exponent
//
// Each item runs a reduction of the base and then, for each of the 31 scanned
// exponent bits, a square plus a multiply when the bit is set. The bit-serial
// modular multiplier retires one multiplier bit per cycle and is shared by the
// reduction, squares and multiplies.
// A modulus below two skips straight to the result, which is then zero.
// Reset (rst_n, synchronous) restores the register reset values and the idle step.
// A result waits in the output register; a stalled sink holds the next result
// in the emit step until the register frees up.
module modular_exponentiation_unit import mexp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mexp_in_if.sink    in_ch,
  mexp_out_if.source out_ch,
  mexp_cfg_if.sink   cfg_ch
);

  // Configuration registers. Writes are only expected while the unit is idle,
  // so the datapath reads them directly.
  operand_t modulus_r;
  operand_t exponent_r;

  // Sequencer.
  pc_t        pc_r;
  pc_t        pc_nxt;
  ctrl_word_t cw;
  logic       cond_true;
  logic       step_done;
  logic       mm_act;

  // Working registers.
  operand_t base_r;
  operand_t red_r;
  operand_t acc_r;
  bit_idx_t bit_r;

  // Bit-serial modular multiplier: p = x * y mod m, y scanned from its MSB.
  logic     mm_busy_r;
  bit_idx_t mm_cnt_r;
  operand_t mm_x_r;
  operand_t mm_y_r;
  operand_t mm_p_r;
  logic     mm_last;
  logic [OPW:0] mm_dbl;
  logic [OPW:0] mm_dbl_red;
  logic [OPW:0] mm_sum;
  logic [OPW:0] mm_sum_red;
  operand_t mm_res;

  // Output register.
  logic     out_valid_r;
  operand_t out_data_r;
  logic     out_busy;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= MODULUS_RST;
      exponent_r <= EXPONENT_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_MODULUS) begin
        modulus_r <= cfg_ch.data;
      end else if (cfg_ch.index == REG_EXPONENT) begin
        exponent_r <= cfg_ch.data;
      end
    end
  end

  assign cw = ucode(pc_r);

  // One multiplier step: double the partial result, add x when the current
  // bit of y is set, and keep both sums below the modulus with one subtract
  // each. Both operands stay below the modulus, so one subtract suffices.
  always_comb begin
    mm_dbl     = {mm_p_r, 1'b0};
    mm_dbl_red = (mm_dbl >= {1'b0, modulus_r}) ? mm_dbl - {1'b0, modulus_r} : mm_dbl;
    mm_sum     = mm_dbl_red + (mm_y_r[OPW-1] ? {1'b0, mm_x_r} : '0);
    mm_sum_red = (mm_sum >= {1'b0, modulus_r}) ? mm_sum - {1'b0, modulus_r} : mm_sum;
    mm_res     = mm_sum_red[OPW-1:0];
  end

  assign mm_last  = mm_busy_r && (mm_cnt_r == '0);
  assign mm_act   = (cw.act == ACT_REDUCE) || (cw.act == ACT_SQR) || (cw.act == ACT_MUL);
  assign out_busy = out_valid_r && !out_ch.ready;

  always_comb begin
    unique case (cw.cond)
      C_NEVER:    cond_true = 1'b0;
      C_NO_IN:    cond_true = !in_ch.valid;
      C_M_SMALL:  cond_true = (modulus_r < operand_t'(2));
      C_EBIT_CLR: cond_true = !exponent_r[bit_r];
      C_BIT_NZ:   cond_true = (bit_r != '0);
      C_OUT_BUSY: cond_true = out_busy;
      default:    cond_true = 1'b0;
    endcase
  end

  // Next step: a multiplier step holds until its last bit, then the
  // condition picks the jump target or the following step.
  always_comb begin
    step_done = mm_act ? mm_last : 1'b1;
    if (!step_done) begin
      pc_nxt = pc_r;
    end else if (cond_true) begin
      pc_nxt = cw.tgt;
    end else begin
      pc_nxt = pc_r + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign in_ch.ready = (cw.act == ACT_ACCEPT);

  // Multiplier control: the first cycle of a multiply step loads the operands,
  // then one bit of y is retired per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_busy_r <= 1'b0;
    end else if (mm_act) begin
      mm_busy_r <= !mm_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mm_act) begin
      if (!mm_busy_r) begin
        mm_cnt_r <= bit_idx_t'(OPW - 1);
        mm_p_r   <= '0;
        unique case (cw.act)
          ACT_REDUCE: begin
            mm_x_r <= operand_t'(1);
            mm_y_r <= base_r;
          end
          ACT_SQR: begin
            mm_x_r <= acc_r;
            mm_y_r <= acc_r;
          end
          default: begin
            mm_x_r <= acc_r;
            mm_y_r <= red_r;
          end
        endcase
      end else begin
        mm_cnt_r <= mm_cnt_r - bit_idx_t'(1);
        mm_p_r   <= mm_res;
        mm_y_r   <= {mm_y_r[OPW-2:0], 1'b0};
      end
    end
  end

  // Datapath actions of the other steps and write-back of multiplier results.
  always_ff @(posedge clk) begin
    unique case (cw.act)
      ACT_ACCEPT: begin
        if (in_ch.valid) begin
          base_r <= in_ch.base;
          acc_r  <= '0;
        end
      end
      ACT_REDUCE: begin
        if (mm_last) begin
          red_r <= mm_res;
        end
      end
      ACT_INIT: begin
        acc_r <= operand_t'(1);
        bit_r <= bit_idx_t'(OPW - 1);
      end
      ACT_SQR, ACT_MUL: begin
        if (mm_last) begin
          acc_r <= mm_res;
        end
      end
      ACT_NEXT: begin
        bit_r <= bit_r - bit_idx_t'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register: loaded by the emit step once the previous transaction
  // has gone or is going out in this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cw.act == ACT_EMIT) && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cw.act == ACT_EMIT) && !out_busy) begin
      out_data_r <= acc_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.power_mod = out_data_r;

endmodule
